### rtl/meter_frame_parser_assert.svh
// Assertion macros shared by the meter frame parser RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled in rst.
`ifndef METER_FRAME_PARSER_ASSERT_SVH
`define METER_FRAME_PARSER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define MFP_ASSERT_NOW(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define MFP_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

### rtl/mfp_pkg.sv
// Package for the meter frame parser: field widths, frame record, kind codes.
// No dependencies; used by mfp_result_if and every RTL module.
package mfp_pkg;

  // Preamble and scope constants
  localparam logic [7:0] PRE_FIRST   = 8'hAA;
  localparam logic [7:0] PRE_SECOND  = 8'h55;
  localparam logic [7:0] SCOPE_CLASS = 8'h0A;
  localparam logic [7:0] SCOPE_FWD   = 8'h02;
  localparam logic [7:0] SCOPE_IND   = 8'h07;
  localparam logic [7:0] SCOPE_CAP   = 8'h0C;
  localparam logic [7:0] SCOPE_REV   = 8'h51;

  // Frame layout counts
  localparam logic [7:0] ID_LAST    = 8'd4;  // index of the fifth ID byte
  localparam logic [7:0] SCOPE_LAST = 8'd1;  // index of the second scope byte
  localparam logic [7:0] CRC_LAST   = 8'd1;  // index of the second CRC byte
  localparam logic [7:0] SIZE_OVERHEAD = 8'd2;

  // Frame kind codes
  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_FWD   = 3'd1;
  localparam logic [2:0] KIND_IND   = 3'd2;
  localparam logic [2:0] KIND_CAP   = 3'd3;
  localparam logic [2:0] KIND_REV   = 3'd4;

  // Queue between parser and result stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] REPORT_RESET = 8'd6;

  // One completed frame as handed from parser to result stage
  typedef struct packed {
    logic [31:0] serial;
    logic [23:0] data;
    logic [2:0]  kind;
    logic [7:0]  size;
    logic [15:0] crc;
  } frame_rec_t;

  // Decode the frame kind from the two scope bytes
  function automatic logic [2:0] kind_of_scope(input logic [15:0] scope);
    logic [2:0] k;
    k = KIND_OTHER;
    if (scope[15:8] == SCOPE_CLASS) begin
      case (scope[7:0])
        SCOPE_FWD: k = KIND_FWD;
        SCOPE_IND: k = KIND_IND;
        SCOPE_CAP: k = KIND_CAP;
        SCOPE_REV: k = KIND_REV;
        default:   k = KIND_OTHER;
      endcase
    end
    return k;
  endfunction

endpackage

### rtl/mfp_ifs.sv
// Valid/ready channel interfaces for the meter frame parser.
// Depends on mfp_pkg, which mfp_result_if imports.
interface mfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mfp_result_if import mfp_pkg::*;;
  logic        valid;
  logic        ready;
  logic [31:0] meter_serial;
  logic [23:0] energy_forward;
  logic [23:0] energy_reverse;
  logic [2:0]  frame_kind;
  logic [7:0]  frame_size;
  logic [15:0] crc_word;
  logic        report;
  modport source (output valid, output meter_serial, output energy_forward,
                  output energy_reverse, output frame_kind, output frame_size,
                  output crc_word, output report, input ready);
  modport sink   (input valid, input meter_serial, input energy_forward,
                  input energy_reverse, input frame_kind, input frame_size,
                  input crc_word, input report, output ready);
endinterface

### rtl/mfp_front.sv
// Front end: byte-serial frame parser, one byte per cycle while the queue has room.
// Depends on mfp_pkg and mfp_byte_if; pushes completed frames into mfp_queue.
module mfp_front import mfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mfp_byte_if.sink   rx,
  input  logic       q_full,
  output logic       push,
  output frame_rec_t rec
);

  typedef enum logic [6:0] {
    ST_HUNT1 = 7'b0000001,
    ST_HUNT2 = 7'b0000010,
    ST_ID    = 7'b0000100,
    ST_SIZE  = 7'b0001000,
    ST_SCOPE = 7'b0010000,
    ST_DATA  = 7'b0100000,
    ST_CRC   = 7'b1000000
  } parse_state_t;

  parse_state_t state, state_next;
  logic [7:0]   byte_count, byte_count_next;
  logic [31:0]  serial_reg;
  logic [7:0]   size_reg;
  logic [15:0]  scope_reg;
  logic [23:0]  data_reg;
  logic [7:0]   crc_hi;

  logic       accept;
  logic [7:0] c;
  logic [7:0] need;
  logic       data_last;

  // Accept whenever the queue has room for a possible frame
  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;
  assign c        = rx.in_byte;

  // Data byte count: size minus two, at least one
  assign need      = (size_reg > SIZE_OVERHEAD) ? (size_reg - SIZE_OVERHEAD) : 8'd1;
  assign data_last = ({1'b0, byte_count} + 9'd1) >= {1'b0, need};

  // Next state and byte counter
  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    case (state)
      ST_HUNT2: begin
        if (c == PRE_SECOND) begin
          state_next      = ST_ID;
          byte_count_next = '0;
        end else if (c != PRE_FIRST) begin
          state_next = ST_HUNT1;
        end
      end
      ST_ID: begin
        byte_count_next = byte_count + 8'd1;
        if (byte_count == ID_LAST) begin
          state_next      = ST_SIZE;
          byte_count_next = '0;
        end
      end
      ST_SIZE: begin
        state_next      = ST_SCOPE;
        byte_count_next = '0;
      end
      ST_SCOPE: begin
        byte_count_next = byte_count + 8'd1;
        if (byte_count == SCOPE_LAST) begin
          state_next      = ST_DATA;
          byte_count_next = '0;
        end
      end
      ST_DATA: begin
        byte_count_next = byte_count + 8'd1;
        if (data_last) begin
          state_next      = ST_CRC;
          byte_count_next = '0;
        end
      end
      ST_CRC: begin
        byte_count_next = byte_count + 8'd1;
        if (byte_count == CRC_LAST) begin
          state_next      = ST_HUNT1;
          byte_count_next = '0;
        end
      end
      default: begin
        // hunting the first preamble byte
        state_next      = (c == PRE_FIRST) ? ST_HUNT2 : ST_HUNT1;
        byte_count_next = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_HUNT1;
      byte_count <= '0;
      data_reg   <= '0;
    end else if (accept) begin
      state      <= state_next;
      byte_count <= byte_count_next;
      // data bytes not received keep the earlier frame's value
      if (state == ST_DATA) begin
        case (byte_count)
          8'd0:    data_reg[23:16] <= c;
          8'd1:    data_reg[15:8]  <= c;
          8'd2:    data_reg[7:0]   <= c;
          default: data_reg        <= data_reg;
        endcase
      end
    end
  end

  // Field capture
  always_ff @(posedge clk) begin
    if (accept) begin
      if (state == ST_ID)    serial_reg <= {serial_reg[23:0], c};
      if (state == ST_SIZE)  size_reg   <= c;
      if (state == ST_SCOPE) scope_reg  <= {scope_reg[7:0], c};
      if (state == ST_CRC)   crc_hi     <= c;
    end
  end

  // Frame completes on the second CRC byte
  assign push = accept && (state == ST_CRC) && (byte_count == CRC_LAST);

  always_comb begin
    rec.serial = serial_reg;
    rec.data   = data_reg;
    rec.kind   = kind_of_scope(scope_reg);
    rec.size   = size_reg;
    rec.crc    = {crc_hi, c};
  end

endmodule

### rtl/mfp_queue.sv
// Short frame queue between the parser and the result stage.
// Depends on mfp_pkg for frame_rec_t and the queue depth.
`include "meter_frame_parser_assert.svh"
module mfp_queue import mfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  input  logic       pop,
  output frame_rec_t pop_rec,
  output logic       full,
  output logic       empty
);

  frame_rec_t          slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_rec = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  `MFP_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue push while full")
  `MFP_ASSERT_NOW(a_no_underflow, pop, !empty, "queue pop while empty")
  `MFP_ASSERT_NEXT(a_count_drop, pop && !push, count == $past(count) - 1'b1,
    "queue count did not drop on pop")

endmodule

### rtl/mfp_back.sv
// Back end: applies energy updates and report counting, holds the result register.
// Depends on mfp_pkg and mfp_result_if; drains frames from mfp_queue.
`include "meter_frame_parser_assert.svh"
module mfp_back import mfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       q_empty,
  input  frame_rec_t q_rec,
  output logic       pop,
  mfp_result_if.source res
);

  logic [7:0]  report_interval;
  logic [7:0]  frame_tally;
  logic [23:0] fwd_total, fwd_total_next;
  logic [23:0] rev_total, rev_total_next;
  logic        rep_next;
  logic [8:0]  tally_inc;

  logic        out_valid;
  logic [31:0] out_serial;
  logic [23:0] out_fwd;
  logic [23:0] out_rev;
  logic [2:0]  out_kind;
  logic [7:0]  out_size;
  logic [15:0] out_crc;
  logic        out_report;

  // Take a frame when the result register is free or being drained
  assign pop = !q_empty && (!out_valid || res.ready);

  assign tally_inc      = {1'b0, frame_tally} + 9'd1;
  assign rep_next       = tally_inc >= {1'b0, report_interval};
  assign fwd_total_next = (q_rec.kind == KIND_FWD) ? q_rec.data : fwd_total;
  assign rev_total_next = (q_rec.kind == KIND_REV) ? q_rec.data : rev_total;

  // Config, totals and report counter
  always_ff @(posedge clk) begin
    if (rst) begin
      report_interval <= REPORT_RESET;
      frame_tally     <= '0;
      fwd_total       <= '0;
      rev_total       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) report_interval <= cfg_data;
      if (pop) begin
        fwd_total   <= fwd_total_next;
        rev_total   <= rev_total_next;
        frame_tally <= rep_next ? 8'd0 : tally_inc[7:0];
        out_valid   <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_serial <= q_rec.serial;
      out_fwd    <= fwd_total_next;
      out_rev    <= rev_total_next;
      out_kind   <= q_rec.kind;
      out_size   <= q_rec.size;
      out_crc    <= q_rec.crc;
      out_report <= rep_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.meter_serial   = out_serial;
  assign res.energy_forward = out_fwd;
  assign res.energy_reverse = out_rev;
  assign res.frame_kind     = out_kind;
  assign res.frame_size     = out_size;
  assign res.crc_word       = out_crc;
  assign res.report         = out_report;

  `MFP_ASSERT_NEXT(a_report_clears, pop && rep_next, frame_tally == '0,
    "report did not clear frame tally")
  `MFP_ASSERT_NEXT(a_fwd_loaded, pop && (q_rec.kind == KIND_FWD),
    fwd_total == out_fwd, "forward total and result disagree")

endmodule

### rtl/meter_frame_parser.sv
// Top level of the meter frame parser: front parser, frame queue, result stage.
// Depends on mfp_pkg, mfp_ifs, mfp_front, mfp_queue and mfp_back.
//
//  channel  | direction | handshake    | payload
//  ---------+-----------+--------------+------------------------------------------
//  rx       | in        | valid/ready  | in_byte
//  frame    | out       | valid/ready  | meter_serial, energy_*, frame_kind, ...
//  cfg      | in        | cfg_we       | cfg_data (report_interval)
//
// One byte is taken every cycle while the queue has room; a frame ends with its last
// CRC byte, is written into the queue and then moves into the result register.
// rx.ready drops only when the four-entry frame queue is full.
// A stalled frame output backs up the queue, never the parser directly.
// rst is synchronous and returns the parser to the preamble hunt.
module meter_frame_parser import mfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mfp_byte_if.sink     rx,
  mfp_result_if.source frame,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data
);

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  frame_rec_t push_rec;
  frame_rec_t pop_rec;

  mfp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .push   (push),
    .rec    (push_rec)
  );

  mfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  mfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_rec    (pop_rec),
    .pop      (pop),
    .res      (frame)
  );

endmodule
